[rtl/nmea_rmc_sentence_parser_top_assert.svh]
// Assertion macros shared by the NMEA RMC parser checker.
// No other dependencies; the user supplies clock, reset and expressions.
`ifndef NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define NRMC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nrmc checker: same-cycle property failed");
// Next-cycle implication, disabled while reset is asserted.
`define NRMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nrmc checker: next-cycle property failed");
`endif

[rtl/nrmc_pkg.sv]
// Package for the NMEA RMC sentence parser: character codes, record types
// and the small arithmetic helpers used by the scanner and formatter.
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

    localparam int MINUTE_FRACTION_DIGITS = 4;
    localparam int FRAC_CNT_W = $clog2(MINUTE_FRACTION_DIGITS + 1);

    localparam int RX_W   = 8;
    localparam int ZONE_W = 11;
    localparam int MIN_ACC_W = 20;
    localparam logic [MIN_ACC_W-1:0] MIN_ACC_MAX = '1;
    localparam int POS_SUM_W = 35;

    localparam logic [34:0] UNITS_PER_DEGREE = 35'd600000;
    localparam logic [27:0] LAT_LIMIT = 28'd54000000;
    localparam logic [27:0] LON_LIMIT = 28'd108000000;

    // Reciprocal constants for exact division by 10 and 100 of a 20-bit value.
    localparam logic [20:0] DIV10_MUL  = 21'd838861;
    localparam int          DIV10_SHR  = 23;
    localparam logic [20:0] DIV100_MUL = 21'd1342178;
    localparam int          DIV100_SHR = 27;

    localparam logic [13:0] MIN_PER_DAY = 14'd1440;

    // Character codes.
    localparam logic [RX_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [RX_W-1:0] CH_G      = 8'h47;
    localparam logic [RX_W-1:0] CH_P      = 8'h50;
    localparam logic [RX_W-1:0] CH_R      = 8'h52;
    localparam logic [RX_W-1:0] CH_M      = 8'h4D;
    localparam logic [RX_W-1:0] CH_C      = 8'h43;
    localparam logic [RX_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [RX_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [RX_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [RX_W-1:0] CH_CR     = 8'h0D;
    localparam logic [RX_W-1:0] CH_LF     = 8'h0A;
    localparam logic [RX_W-1:0] CH_A      = 8'h41;
    localparam logic [RX_W-1:0] CH_S      = 8'h53;
    localparam logic [RX_W-1:0] CH_W      = 8'h57;
    localparam logic [RX_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [RX_W-1:0] CH_NINE   = 8'h39;

    // Field numbers within the sentence.
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_DATE   = 4'd9;

    typedef enum logic [6:0] {
        ST_IDLE        = 7'b0000001,
        ST_SEEN_DOLLAR = 7'b0000010,
        ST_SEEN_G      = 7'b0000100,
        ST_SEEN_P      = 7'b0001000,
        ST_SEEN_R      = 7'b0010000,
        ST_SEEN_M      = 7'b0100000,
        ST_BODY        = 7'b1000000
    } hdr_state_t;

    // Accumulated contents of one sentence.
    typedef struct packed {
        logic [6:0]            hh;
        logic [6:0]            mm;
        logic [6:0]            ss;
        logic                  status;
        logic [6:0]            lat_deg;
        logic [MIN_ACC_W-1:0]  lat_min;
        logic [FRAC_CNT_W-1:0] lat_cnt;
        logic [9:0]            lon_deg;
        logic [MIN_ACC_W-1:0]  lon_min;
        logic [FRAC_CNT_W-1:0] lon_cnt;
        logic                  south;
        logic                  west;
        logic [6:0]            day;
        logic [6:0]            month;
        logic [6:0]            year;
    } sentence_t;

    // One result; hour sits in the lowest bits.
    typedef struct packed {
        logic [6:0]         year;
        logic [6:0]         month;
        logic [6:0]         day;
        logic signed [27:0] longitude;
        logic signed [26:0] latitude;
        logic               fix_valid;
        logic [5:0]         second;
        logic [5:0]         minute;
        logic [4:0]         hour;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    function automatic logic is_digit(input logic [RX_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [3:0] digit_of(input logic [RX_W-1:0] c);
        logic [RX_W-1:0] diff;
        diff = c - CH_ZERO;
        return is_digit(c) ? diff[3:0] : 4'd0;
    endfunction

    // First digit of a pair sets tens, the second adds the units.
    function automatic logic [6:0] pair_update(input logic [6:0] pair, input logic odd,
                                               input logic [3:0] d);
        return odd ? (pair + 7'(d)) : (7'(d) * 7'd10);
    endfunction

    function automatic logic [MIN_ACC_W-1:0] min_accum(input logic [MIN_ACC_W-1:0] acc,
                                                       input logic [3:0] d);
        logic [MIN_ACC_W+3:0] wide;
        wide = (MIN_ACC_W+4)'(acc) * (MIN_ACC_W+4)'(10) + (MIN_ACC_W+4)'(d);
        return (wide > (MIN_ACC_W+4)'(MIN_ACC_MAX)) ? MIN_ACC_MAX : wide[MIN_ACC_W-1:0];
    endfunction

    // Minutes accumulator to units of 1/10000 minute, given the number of
    // fraction digits that were received.
    function automatic logic [POS_SUM_W-1:0] scale_minutes(input logic [MIN_ACC_W-1:0] acc,
                                                           input logic [2:0] cnt);
        logic [MIN_ACC_W+20:0] prod;
        logic [POS_SUM_W-1:0]  res;
        prod = '0;
        case (cnt)
            3'd0: res = POS_SUM_W'(acc) * POS_SUM_W'(10000);
            3'd1: res = POS_SUM_W'(acc) * POS_SUM_W'(1000);
            3'd2: res = POS_SUM_W'(acc) * POS_SUM_W'(100);
            3'd3: res = POS_SUM_W'(acc) * POS_SUM_W'(10);
            3'd4: res = POS_SUM_W'(acc);
            3'd5: begin
                prod = (MIN_ACC_W+21)'(acc) * (MIN_ACC_W+21)'(DIV10_MUL);
                res  = POS_SUM_W'(prod >> DIV10_SHR);
            end
            3'd6: begin
                prod = (MIN_ACC_W+21)'(acc) * (MIN_ACC_W+21)'(DIV100_MUL);
                res  = POS_SUM_W'(prod >> DIV100_SHR);
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/nmea_rmc_sentence_parser_top.sv]
// A result beat appears on m_ in the cycle after the '*' beat is accepted.
// Throughput: one character beat per cycle; the single output register
// holds off s_tready only while a result waits.
// Reset (aresetn low, synchronous): parser idle, zone offset 0, no result pending.
// Top level of the NMEA RMC parser; uses nrmc_pkg, nrmc_scanner, nrmc_formatter.
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_sentence_parser_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nrmc_pkg::ZONE_W-1:0]   cfg_wr_data,  // zone_offset_minutes
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nrmc_pkg::RX_W-1:0]     s_tdata,      // rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hour, minute, second, fix_valid, latitude, longitude, day, month, year
    output logic [nrmc_pkg::TDATA_W-1:0]       m_tdata
);
    import nrmc_pkg::*;

    logic signed [ZONE_W-1:0] zone_reg;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_data_reg, out_data_next;
    result_t                  formatted;
    sentence_t                sentence;
    logic                     beat_accept;
    logic                     emit;

    assign s_tready    = !out_valid_reg || m_tready;
    assign beat_accept = s_tvalid && s_tready;

    nrmc_scanner u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_accept),
        .rx_byte    (s_tdata),
        .sentence   (sentence),
        .emit       (emit)
    );

    nrmc_formatter u_formatter (
        .sentence    (sentence),
        .zone_offset (zone_reg),
        .result      (formatted)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = formatted;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                zone_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-RESULT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[rtl/nrmc_scanner.sv]
// Character scanner: header match, field counting and per-field accumulators.
// Depends on nrmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrmc_scanner (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    beat_valid,
    input  wire logic [nrmc_pkg::RX_W-1:0] rx_byte,
    output nrmc_pkg::sentence_t          sentence,
    output logic                         emit
);
    import nrmc_pkg::*;

    hdr_state_t            state_reg, state_next;
    logic [3:0]            field_reg, field_next;
    logic [3:0]            pos_reg, pos_next;
    logic                  point_reg, point_next;
    sentence_t             sent_reg, sent_next;

    localparam logic [FRAC_CNT_W-1:0] FRAC_MAX = FRAC_CNT_W'(MINUTE_FRACTION_DIGITS);

    always_comb begin
        logic [3:0] d;
        d          = digit_of(rx_byte);
        state_next = state_reg;
        field_next = field_reg;
        pos_next   = pos_reg;
        point_next = point_reg;
        sent_next  = sent_reg;
        emit       = 1'b0;

        if (beat_valid) begin
            if (rx_byte == CH_DOLLAR) begin
                state_next = ST_SEEN_DOLLAR;
            end else begin
                case (state_reg)
                    ST_IDLE: state_next = ST_IDLE;
                    ST_SEEN_DOLLAR: state_next = (rx_byte == CH_G) ? ST_SEEN_G : ST_IDLE;
                    ST_SEEN_G:      state_next = (rx_byte == CH_P) ? ST_SEEN_P : ST_IDLE;
                    ST_SEEN_P:      state_next = (rx_byte == CH_R) ? ST_SEEN_R : ST_IDLE;
                    ST_SEEN_R:      state_next = (rx_byte == CH_M) ? ST_SEEN_M : ST_IDLE;
                    ST_SEEN_M: begin
                        if (rx_byte == CH_C) begin
                            // Header complete: start a fresh sentence.
                            state_next = ST_BODY;
                            field_next = '0;
                            pos_next   = '0;
                            point_next = 1'b0;
                            sent_next  = '0;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    ST_BODY: begin
                        if (rx_byte == CH_CR || rx_byte == CH_LF) begin
                            state_next = ST_IDLE;
                        end else if (rx_byte == CH_COMMA) begin
                            if (field_reg != 4'hF) begin
                                field_next = field_reg + 4'd1;
                            end
                            pos_next   = '0;
                            point_next = 1'b0;
                        end else if (rx_byte == CH_STAR) begin
                            state_next = ST_IDLE;
                            emit       = 1'b1;
                        end else begin
                            case (field_reg)
                                FLD_TIME: begin
                                    if (pos_reg < 4'd6) begin
                                        case (pos_reg[2:1])
                                            2'd0: sent_next.hh =
                                                pair_update(sent_reg.hh, pos_reg[0], d);
                                            2'd1: sent_next.mm =
                                                pair_update(sent_reg.mm, pos_reg[0], d);
                                            default: sent_next.ss =
                                                pair_update(sent_reg.ss, pos_reg[0], d);
                                        endcase
                                    end
                                end
                                FLD_STATUS: begin
                                    if (pos_reg == 4'd0) begin
                                        sent_next.status = (rx_byte == CH_A);
                                    end
                                end
                                FLD_LAT: begin
                                    if (pos_reg < 4'd2) begin
                                        sent_next.lat_deg = 7'(sent_reg.lat_deg * 7'd10 + 7'(d));
                                    end else if (rx_byte == CH_DOT) begin
                                        point_next = 1'b1;
                                    end else if (is_digit(rx_byte) &&
                                                 !(point_reg && sent_reg.lat_cnt >= FRAC_MAX)) begin
                                        if (point_reg) begin
                                            sent_next.lat_cnt =
                                                sent_reg.lat_cnt + FRAC_CNT_W'(1);
                                        end
                                        sent_next.lat_min = min_accum(sent_reg.lat_min, d);
                                    end
                                end
                                FLD_NS: sent_next.south = (pos_reg == 4'd0) && (rx_byte == CH_S);
                                FLD_LON: begin
                                    if (pos_reg < 4'd3) begin
                                        sent_next.lon_deg =
                                            10'(sent_reg.lon_deg * 10'd10 + 10'(d));
                                    end else if (rx_byte == CH_DOT) begin
                                        point_next = 1'b1;
                                    end else if (is_digit(rx_byte) &&
                                                 !(point_reg && sent_reg.lon_cnt >= FRAC_MAX)) begin
                                        if (point_reg) begin
                                            sent_next.lon_cnt =
                                                sent_reg.lon_cnt + FRAC_CNT_W'(1);
                                        end
                                        sent_next.lon_min = min_accum(sent_reg.lon_min, d);
                                    end
                                end
                                FLD_EW: sent_next.west = (pos_reg == 4'd0) && (rx_byte == CH_W);
                                FLD_DATE: begin
                                    if (pos_reg < 4'd6) begin
                                        case (pos_reg[2:1])
                                            2'd0: sent_next.day =
                                                pair_update(sent_reg.day, pos_reg[0], d);
                                            2'd1: sent_next.month =
                                                pair_update(sent_reg.month, pos_reg[0], d);
                                            default: sent_next.year =
                                                pair_update(sent_reg.year, pos_reg[0], d);
                                        endcase
                                    end
                                end
                                default: ;
                            endcase
                            if (pos_reg != 4'hF) begin
                                pos_next = pos_reg + 4'd1;
                            end
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            field_reg <= '0;
            pos_reg   <= '0;
            point_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            field_reg <= field_next;
            pos_reg   <= pos_next;
            point_reg <= point_next;
        end
    end

    // Accumulators are cleared whenever a header completes, so they need no reset.
    always_ff @(posedge aclk) begin
        sent_reg <= sent_next;
    end

    assign sentence = sent_reg;

endmodule

`default_nettype wire

[rtl/nrmc_formatter.sv]
// Result formatter: local time of day, saturated second, fixed-point position.
// Purely combinational; depends on nrmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrmc_formatter (
    input  wire nrmc_pkg::sentence_t            sentence,
    input  wire logic signed [nrmc_pkg::ZONE_W-1:0] zone_offset,
    output nrmc_pkg::result_t                   result
);
    import nrmc_pkg::*;

    logic [13:0] tsum;
    logic [10:0] tod;
    logic [4:0]  hr;
    logic [10:0] hr_min;
    logic [10:0] min_left;
    logic [POS_SUM_W-1:0] lat_total, lon_total;
    logic [27:0] lat_mag, lon_mag;

    // A day is added up front so that the sum is never negative.
    assign tsum = 14'(sentence.hh) * 14'd60 + 14'(sentence.mm)
                + {{(14-ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset} + MIN_PER_DAY;

    always_comb begin
        if (tsum >= 14'(5 * 1440)) begin
            tod = 11'(tsum - 14'(5 * 1440));
        end else if (tsum >= 14'(4 * 1440)) begin
            tod = 11'(tsum - 14'(4 * 1440));
        end else if (tsum >= 14'(3 * 1440)) begin
            tod = 11'(tsum - 14'(3 * 1440));
        end else if (tsum >= 14'(2 * 1440)) begin
            tod = 11'(tsum - 14'(2 * 1440));
        end else if (tsum >= MIN_PER_DAY) begin
            tod = 11'(tsum - MIN_PER_DAY);
        end else begin
            tod = 11'(tsum);
        end
    end

    always_comb begin
        hr = '0;
        for (int j = 1; j < 24; j++) begin
            if (tod >= 11'(j * 60)) begin
                hr = 5'(j);
            end
        end
    end

    assign hr_min   = 11'(hr) * 11'd60;
    assign min_left = tod - hr_min;

    assign lat_total = POS_SUM_W'(sentence.lat_deg) * UNITS_PER_DEGREE
                     + scale_minutes(sentence.lat_min, 3'(sentence.lat_cnt));
    assign lon_total = POS_SUM_W'(sentence.lon_deg) * UNITS_PER_DEGREE
                     + scale_minutes(sentence.lon_min, 3'(sentence.lon_cnt));

    assign lat_mag = (lat_total > POS_SUM_W'(LAT_LIMIT)) ? LAT_LIMIT : lat_total[27:0];
    assign lon_mag = (lon_total > POS_SUM_W'(LON_LIMIT)) ? LON_LIMIT : lon_total[27:0];

    always_comb begin
        result.hour      = hr;
        result.minute    = min_left[5:0];
        result.second    = (sentence.ss > 7'd59) ? 6'd59 : sentence.ss[5:0];
        result.fix_valid = sentence.status;
        result.latitude  = sentence.south ? 27'(28'd0 - lat_mag) : lat_mag[26:0];
        result.longitude = sentence.west ? (28'd0 - lon_mag) : lon_mag;
        result.day       = sentence.day;
        result.month     = sentence.month;
        result.year      = sentence.year;
    end

endmodule

`default_nettype wire

[rtl/nrmc_checker.sv]
// Port-level checker for the NMEA RMC parser and its bind to the top level.
// Depends on nrmc_pkg and nmea_rmc_sentence_parser_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_sentence_parser_top_assert.svh"

module nrmc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [nrmc_pkg::RX_W-1:0]   s_tdata,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [nrmc_pkg::TDATA_W-1:0] m_tdata
);
    import nrmc_pkg::*;

    result_t res;
    logic    out_stall;
    logic    plain_beat;
    logic    time_ok;

    assign res        = m_tdata[RESULT_W-1:0];
    assign out_stall  = m_tvalid && !m_tready;
    assign plain_beat = s_tvalid && s_tready && (s_tdata != CH_STAR);
    assign time_ok    = (res.hour <= 5'd23) && (res.minute <= 6'd59) && (res.second <= 6'd59);

    // A waiting result beat holds still.
    `NRMC_ASSERT_NEXT(a_result_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))
    // Input is taken exactly when the output register is free or draining.
    `NRMC_ASSERT_SAME(a_ready_rule, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    // Only a '*' beat can produce a new result.
    `NRMC_ASSERT_NEXT(a_no_spurious, aclk, aresetn, plain_beat, !m_tvalid)
    // Local time of day and second are always in range.
    `NRMC_ASSERT_SAME(a_time_range, aclk, aresetn, m_tvalid, time_ok)

endmodule

bind nmea_rmc_sentence_parser_top nrmc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/nrmc_fix_checker.sv]
// Scoreboard for the NMEA RMC parser: follows the character and result beats,
// predicts every fix from the character stream and compares it field by field.
// Depends on nrmc_pkg for widths, character codes and the result layout.
`timescale 1ns / 1ps

module nrmc_fix_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nrmc_pkg::ZONE_W-1:0]  cfg_wr_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [nrmc_pkg::RX_W-1:0]    s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [nrmc_pkg::TDATA_W-1:0] m_tdata,
    output int                           mismatches,
    output int                           fixes_waiting,
    output int                           fixes_checked
);
    import nrmc_pkg::*;

    localparam int HDR_IDLE = 0;
    localparam int HDR_BODY = 6;
    localparam int SAT_COUNT = 15;

    // Parser view of the current sentence.
    int                       hdr_pos;
    int                       field_no;
    int                       field_pos;
    logic [6:0]               clock_pair [3];
    logic [6:0]               date_pair [3];
    logic                     status_a;
    int                       lat_deg;
    int                       lon_deg;
    int unsigned              lat_min;
    int unsigned              lon_min;
    int                       lat_frac;
    int                       lon_frac;
    logic                     point_seen;
    logic                     south;
    logic                     west;
    logic signed [ZONE_W-1:0] zone;
    result_t                  fix_q[$];

    function automatic logic [RX_W-1:0] header_char(input int pos);
        case (pos)
            0:       return CH_DOLLAR;
            1:       return CH_G;
            2:       return CH_P;
            3:       return CH_R;
            4:       return CH_M;
            default: return CH_C;
        endcase
    endfunction

    function automatic int numeral(input logic [RX_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : 0;
    endfunction

    // Even positions load the tens digit, odd positions add the units.
    function automatic logic [6:0] next_pair(input logic [6:0] pair, input int pos,
                                             input logic [RX_W-1:0] c);
        return pos[0] ? 7'(int'(pair) + numeral(c)) : 7'(numeral(c) * 10);
    endfunction

    function automatic longint position(input int deg, input longint acc, input int frac,
                                        input longint limit);
        longint v;
        int     k;
        v = acc;
        for (k = frac; k < MINUTE_FRACTION_DIGITS; k++) v = v * 10;
        for (k = MINUTE_FRACTION_DIGITS; k < 4; k++) v = v * 10;
        for (k = 4; k < MINUTE_FRACTION_DIGITS; k++) v = v / 10;
        v = v + longint'(deg) * longint'(UNITS_PER_DEGREE);
        return (v > limit) ? limit : v;
    endfunction

    task automatic clear_sentence();
        field_no   = 0;
        field_pos  = 0;
        clock_pair = '{default: '0};
        date_pair  = '{default: '0};
        status_a   = 1'b0;
        lat_deg    = 0;
        lon_deg    = 0;
        lat_min    = 0;
        lon_min    = 0;
        lat_frac   = 0;
        lon_frac   = 0;
        point_seen = 1'b0;
        south      = 1'b0;
        west       = 1'b0;
    endtask

    task automatic minute_char(inout int unsigned acc, inout int frac,
                               input logic [RX_W-1:0] c);
        longint v;
        if (c == CH_DOT) begin
            point_seen = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE
                     && !(point_seen && frac >= MINUTE_FRACTION_DIGITS)) begin
            if (point_seen) frac++;
            v   = longint'(acc) * 10 + numeral(c);
            acc = (v > longint'(MIN_ACC_MAX)) ? int'(MIN_ACC_MAX) : int'(v);
        end
    endtask

    task automatic body_char(input logic [RX_W-1:0] c);
        case (field_no)
            FLD_TIME: begin
                if (field_pos < 6)
                    clock_pair[field_pos / 2] = next_pair(clock_pair[field_pos / 2],
                                                          field_pos, c);
            end
            FLD_STATUS: begin
                if (field_pos == 0) status_a = (c == CH_A);
            end
            FLD_LAT: begin
                if (field_pos < 2) lat_deg = lat_deg * 10 + numeral(c);
                else minute_char(lat_min, lat_frac, c);
            end
            FLD_NS: south = (field_pos == 0 && c == CH_S);
            FLD_LON: begin
                if (field_pos < 3) lon_deg = lon_deg * 10 + numeral(c);
                else minute_char(lon_min, lon_frac, c);
            end
            FLD_EW: west = (field_pos == 0 && c == CH_W);
            FLD_DATE: begin
                if (field_pos < 6)
                    date_pair[field_pos / 2] = next_pair(date_pair[field_pos / 2],
                                                         field_pos, c);
            end
            default: ;
        endcase
        if (field_pos < SAT_COUNT) field_pos++;
    endtask

    function automatic result_t build_fix();
        result_t r;
        int      t;
        int      sec;
        longint  lat;
        longint  lon;
        // Time of day wraps around midnight; the date is left as received.
        t = int'(clock_pair[0]) * 60 + int'(clock_pair[1]) + int'(zone);
        t = t % 1440;
        if (t < 0) t += 1440;
        sec = int'(clock_pair[2]);
        if (sec > 59) sec = 59;
        lat = position(lat_deg, lat_min, lat_frac, longint'(LAT_LIMIT));
        lon = position(lon_deg, lon_min, lon_frac, longint'(LON_LIMIT));
        if (south) lat = -lat;
        if (west) lon = -lon;
        r.hour      = 5'(t / 60);
        r.minute    = 6'(t % 60);
        r.second    = 6'(sec);
        r.fix_valid = status_a;
        r.latitude  = 27'(lat);
        r.longitude = 28'(lon);
        r.day       = date_pair[0];
        r.month     = date_pair[1];
        r.year      = date_pair[2];
        return r;
    endfunction

    task automatic take_char(input logic [RX_W-1:0] c);
        if (c == CH_DOLLAR) begin
            hdr_pos = 1;
        end else if (hdr_pos >= 1 && hdr_pos < HDR_BODY) begin
            if (c == header_char(hdr_pos)) begin
                hdr_pos++;
                if (hdr_pos == HDR_BODY) clear_sentence();
            end else begin
                hdr_pos = HDR_IDLE;
            end
        end else if (hdr_pos == HDR_BODY) begin
            if (c == CH_CR || c == CH_LF) begin
                hdr_pos = HDR_IDLE;
            end else if (c == CH_COMMA) begin
                if (field_no < SAT_COUNT) field_no++;
                field_pos  = 0;
                point_seen = 1'b0;
            end else if (c == CH_STAR) begin
                hdr_pos = HDR_IDLE;
                fix_q.push_back(build_fix());
            end else begin
                body_char(c);
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: fix %0d field %s expected %0d actual %0d",
                     $time, fixes_checked, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_fix(input result_t got);
        result_t want;
        if (fix_q.size() == 0) begin
            $display("%0t: result beat with no fix expected, actual %h", $time, got);
            mismatches++;
        end else begin
            want = fix_q.pop_front();
            check_field("hour", want.hour, got.hour);
            check_field("minute", want.minute, got.minute);
            check_field("second", want.second, got.second);
            check_field("fix_valid", want.fix_valid, got.fix_valid);
            check_field("latitude", want.latitude, got.latitude);
            check_field("longitude", want.longitude, got.longitude);
            check_field("day", want.day, got.day);
            check_field("month", want.month, got.month);
            check_field("year", want.year, got.year);
            fixes_checked++;
        end
    endtask

    initial begin
        mismatches    = 0;
        fixes_waiting = 0;
        fixes_checked = 0;
        hdr_pos       = HDR_IDLE;
        zone          = '0;
        clear_sentence();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos = HDR_IDLE;
            zone    = '0;
            clear_sentence();
            fix_q.delete();
        end else begin
            if (cfg_wr_en) zone = cfg_wr_data;
            // Results go first so that a fix predicted at this edge is never
            // matched against a beat that left the block earlier.
            if (m_tvalid && m_tready) compare_fix(result_t'(m_tdata[RESULT_W-1:0]));
            if (s_tvalid && s_tready) take_char(s_tdata);
        end
        fixes_waiting = fix_q.size();
    end

endmodule

[test/tb_nmea_rmc_sentence_parser_top.sv]
// Testbench top for the NMEA RMC parser: drives sentences, broken sentences and
// noise with random stalls on both sides under several zone offsets.
// Depends on nrmc_pkg, the parser RTL and nrmc_fix_checker.
`timescale 1ns / 1ps

module tb_nmea_rmc_sentence_parser_top;
    import nrmc_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int CHARS_PER_PHASE = 160;
    localparam int PHASES          = 6;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [ZONE_W-1:0]  cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [RX_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    int mismatches;
    int fixes_waiting;
    int fixes_checked;

    logic [RX_W-1:0] line_q[$];
    string           hex_digits = "0123456789ABCDEF";
    int              chars_sent;
    int              zones_used;
    int              stall_cycles;
    int              src_gap_pct;
    int              sink_gap_pct;
    bit              calm;

    nmea_rmc_sentence_parser_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    nrmc_fix_checker u_fix_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .fixes_waiting (fixes_waiting),
        .fixes_checked (fixes_checked)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int pick_gap_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 6;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    // Printable filler that never opens, separates or closes a sentence.
    function automatic logic [RX_W-1:0] junk_char();
        logic [RX_W-1:0] c;
        do c = RX_W'($urandom_range(33, 126));
        while (c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR);
        return c;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic push_eol();
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
    endtask

    task automatic push_num(input int v, input int w);
        int k;
        int p;
        p = 1;
        for (k = 1; k < w; k++) p = p * 10;
        for (k = 0; k < w; k++) begin
            line_q.push_back(CH_ZERO + RX_W'((v / p) % 10));
            p = p / 10;
        end
    endtask

    task automatic push_digits(input int n);
        repeat (n) line_q.push_back(CH_ZERO + RX_W'($urandom_range(0, 9)));
    endtask

    task automatic push_junk(input int n);
        repeat (n) line_q.push_back(junk_char());
    endtask

    // Degrees and decimal minutes, mostly well formed.
    task automatic push_coord(input int deg_w, input int deg_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            push_num($urandom_range(0, deg_max), deg_w);
            push_num($urandom_range(0, 59), 2);
            if ($urandom_range(0, 99) < 85) begin
                line_q.push_back(CH_DOT);
                push_digits($urandom_range(0, 6));
            end
        end else if (r < 93) begin
            push_digits($urandom_range(0, 12));
        end else begin
            push_junk($urandom_range(0, 4));
        end
    endtask

    task automatic push_letter(input logic [RX_W-1:0] plus, input logic [RX_W-1:0] minus);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: line_q.push_back(plus);
            4, 5, 6, 7: line_q.push_back(minus);
            8:          ;
            default:    push_junk($urandom_range(1, 2));
        endcase
    endtask

    task automatic make_fix_sentence();
        int r;
        push_text("$GPRMC,");
        r = $urandom_range(0, 99);
        if (r < 80) begin
            push_num($urandom_range(0, 23), 2);
            push_num($urandom_range(0, 59), 2);
            push_num($urandom_range(0, 59), 2);
        end else if (r < 92) begin
            push_num($urandom_range(0, 999999), 6);
        end else begin
            push_junk($urandom_range(0, 8));
        end
        if ($urandom_range(0, 1)) begin
            line_q.push_back(CH_DOT);
            push_digits($urandom_range(1, 3));
        end
        line_q.push_back(CH_COMMA);
        r = $urandom_range(0, 9);
        if (r < 6) line_q.push_back(CH_A);
        else if (r < 9) push_text("V");
        else push_junk($urandom_range(0, 2));
        line_q.push_back(CH_COMMA);
        push_coord(2, 90);
        line_q.push_back(CH_COMMA);
        push_letter("N", CH_S);
        line_q.push_back(CH_COMMA);
        push_coord(3, 180);
        line_q.push_back(CH_COMMA);
        push_letter("E", CH_W);
        line_q.push_back(CH_COMMA);
        repeat (2) begin
            if ($urandom_range(0, 1)) begin
                push_num($urandom_range(0, 999), 3);
                line_q.push_back(CH_DOT);
                push_digits(1);
            end
            line_q.push_back(CH_COMMA);
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            push_num($urandom_range(1, 31), 2);
            push_num($urandom_range(1, 12), 2);
            push_num($urandom_range(0, 99), 2);
        end else if (r < 93) begin
            push_digits($urandom_range(0, 8));
        end else begin
            push_junk($urandom_range(1, 6));
        end
        r = $urandom_range(0, 9);
        if (r < 3) push_text(",003.1,W");
        else if (r < 4) push_text(",,,,,,,A");
        line_q.push_back(CH_STAR);
        line_q.push_back(hex_digits[$urandom_range(0, 15)]);
        line_q.push_back(hex_digits[$urandom_range(0, 15)]);
        if ($urandom_range(0, 9) < 8) push_eol();
    endtask

    task automatic make_broken();
        int cut;
        case ($urandom_range(0, 2))
            0: begin
                // A sentence cut short, then a line end or simply the next header.
                make_fix_sentence();
                cut = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > cut) void'(line_q.pop_back());
                case ($urandom_range(0, 2))
                    0:       line_q.push_back(CH_CR);
                    1:       line_q.push_back(CH_LF);
                    default: ;
                endcase
            end
            1: begin
                push_text("$GPRM");
                line_q.push_back(junk_char());
                push_text(",123519,A,4807.038,N*");
            end
            default: begin
                push_text("$GPGGA,");
                push_digits(6);
                push_text(",A*");
            end
        endcase
    endtask

    task automatic make_noise();
        repeat ($urandom_range(1, 12)) line_q.push_back(RX_W'($urandom_range(0, 255)));
    endtask

    task automatic push_char(input logic [RX_W-1:0] c);
        int n;
        if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_line();
        src_gap_pct = pick_gap_pct();
        while (line_q.size() > 0) push_char(line_q.pop_front());
    endtask

    // Valid drops here and is raised no earlier than the next falling edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (fixes_waiting != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_zone(input int minutes);
        wait_idle();
        cfg_wr_data <= ZONE_W'(minutes);
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        zones_used++;
    endtask

    task automatic run_directed();
        string lines [$];
        lines = '{
            "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
            "$GPRMC,235959,A,8959.9999,N,17959.9999,E,,,311299*00",
            "$GPRMC,000000,V,0000.0000,S,00000.0000,W,,,000000*00",
            "$GPRMC,996099,A,9959.9999,S,99999.9999,W,,,999999*00",
            "$GPRMC,1a2b3c.45,AV,4x07.1,N,0x112.5,E,,,0x0y0z99*00",
            "$GPRMC,120000,a,4807,SX,01131.123456,WE,,,010203*00",
            "$GPRMC,120000,A,48.07.5z9,S,011999999999999,W,,,010203*00",
            "$GPRMC*",
            "$GPRMC,123456789012345678,,,,,,,,,,,,,,,,,,,,12345*",
            "$GP$GPRMC,010203,A,,,,,,,150620*",
            "$$GPRMC,2359,V,12,N,123,E,,,1*",
            "$GPRMC,111111,A,1234.5,S$GPRMC,222222,V,,,,,,,,,*",
            "$GPGGA,123519,4807.038,N*47",
            "$GPRMX,123519*",
            "*,A$GPRM*"
        };
        foreach (lines[i]) begin
            push_text(lines[i]);
            push_eol();
            send_line();
        end
        // A line end inside a sentence drops it; the later '*' is outside.
        push_text("$GPRMC,123456,A");
        line_q.push_back(CH_CR);
        push_text(",4807.038,N*$GPRMC,654321,A");
        line_q.push_back(CH_LF);
        push_text(",,,,,,,,010101*");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        push_eol();
        send_line();
    endtask

    // Result side: random stall bursts, with the rate changed now and then.
    initial begin : sink_pacing
        int cycles;
        int n;
        m_tready     = 1'b0;
        sink_gap_pct = 0;
        cycles       = 0;
        forever begin
            @(negedge aclk);
            if (cycles % 100 == 0) sink_gap_pct = pick_gap_pct();
            cycles++;
            if (!calm && aresetn && $urandom_range(0, 99) < sink_gap_pct) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge aclk);
                cycles += n;
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d fixes outstanding",
                     $time, STALL_LIMIT, fixes_waiting);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int zone_plan [PHASES];
        int phase_start;
        int r;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        calm         = 1'b0;
        src_gap_pct  = 0;
        chars_sent   = 0;
        zones_used   = 0;
        stall_cycles = 0;
        zone_plan[0] = -840;
        zone_plan[1] = 840;
        zone_plan[2] = $urandom_range(0, 1680) - 840;
        zone_plan[3] = -1;
        zone_plan[4] = 0;
        zone_plan[5] = $urandom_range(0, 1680) - 840;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            set_zone(zone_plan[ph]);
            // The closing phase runs with no stalls on either side.
            if (ph == PHASES - 1) calm = 1'b1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < CHARS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 75) make_fix_sentence();
                else if (r < 87) make_broken();
                else make_noise();
                send_line();
            end
        end

        wait_idle();
        $display("Sent %0d characters under %0d zone offset settings, with stalls on",
                 chars_sent, zones_used + 1);
        $display("both sides and a stall-free tail; %0d fixes compared, %0d bad fields.",
                 fixes_checked, mismatches);
        if (mismatches == 0 && fixes_waiting == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
